### design/robin_hood_hash_table_top_macros.svh
// Assertion macros for the Robin Hood hash table.
`ifndef ROBIN_HOOD_HASH_TABLE_TOP_MACROS_SVH
`define ROBIN_HOOD_HASH_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("robin hood table check failed");
`define RH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("robin hood table check failed");
`else
`define RH_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/rhht_pkg.sv
// Types and constants for the Robin Hood hash table.
package rhht_pkg;
	localparam int KEY_W   = 32;
	localparam int DATA_W  = 32;
	localparam int DIST_W  = 5;
	localparam int COUNT_W = 11;
	localparam int HASH_SHIFT = 16;
	localparam logic [31:0] HASH_MULT = 32'h045d9f3b;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_SPARE  = 2'd3;

	localparam logic [2:0] ST_NEW     = 3'd0;
	localparam logic [2:0] ST_UPDATED = 3'd1;
	localparam logic [2:0] ST_FOUND   = 3'd2;
	localparam logic [2:0] ST_MISSING = 3'd3;
	localparam logic [2:0] ST_DROPPED = 3'd4;
	localparam logic [2:0] ST_CLEARED = 3'd5;

	typedef struct packed {
		logic [1:0]        command;
		logic [KEY_W-1:0]  key_in;
		logic [DATA_W-1:0] data_in;
	} req_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [DATA_W-1:0]  value_out;
		logic [KEY_W-1:0]   dropped_key;
		logic [COUNT_W-1:0] entry_count;
	} rsp_item_t;

	typedef struct packed {
		logic              full;
		logic [DIST_W-1:0] distance;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
	} cell_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_HASH,
		FSM_READ,
		FSM_CHECK,
		FSM_SWEEP,
		FSM_DONE
	} fsm_t;
endpackage

### design/robin_hood_hash_table_top.sv
// Robin Hood hash table: cell memory, probe sequencer and result register.
// Insert/lookup: a hash step, then per probed cell one read and one check/write-back step, and
// a final read step when the probe limit ends the walk; each item then passes the done step.
// Clear: writes each of the TABLE_SIZE+TABLE_LOG+1 cells in turn, then one result.
// After reset the same clearing pass runs with no result; req_stall stays high meanwhile.
// One item in flight; a finished result waits in the output register.
`include "robin_hood_hash_table_top_macros.svh"
module robin_hood_hash_table_top
	import rhht_pkg::*;
#(
	parameter int TABLE_LOG = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);
	localparam int CELL_COUNT = (1 << TABLE_LOG) + TABLE_LOG + 1;
	localparam int IDX_W = $clog2(CELL_COUNT);
	localparam int IND_W = $clog2(CELL_COUNT + 1);

	cell_t mem [CELL_COUNT];
	cell_t rd_s1;
	logic mem_we, rd_en;
	logic [IDX_W-1:0] mem_wa, mem_ra;
	cell_t mem_wd;

	fsm_t state_q, state_d;
	logic [1:0] cmd_q, cmd_d;
	logic [KEY_W-1:0] key_q, key_d;
	logic [DATA_W-1:0] val_q, val_d;
	logic [DIST_W-1:0] dist_q, dist_d;
	logic [IND_W-1:0] ind_q, ind_d;
	logic [COUNT_W-1:0] occ_q, occ_d;
	logic emit_q, emit_d;
	rsp_item_t res_q, res_d, out_q, out_d;
	logic out_valid_q, out_valid_d;

	logic [31:0] mix, prod;
	logic is_insert, in_bound;

	assign mix = key_q ^ (key_q >> HASH_SHIFT);
	assign prod = mix * HASH_MULT;
	assign is_insert = (cmd_q == CMD_INSERT);
	assign in_bound = (ind_q < IND_W'(CELL_COUNT)) &&
		(is_insert ? (dist_q < DIST_W'(TABLE_LOG)) : (dist_q <= DIST_W'(TABLE_LOG)));

	assign req_stall = (state_q != FSM_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_s1 <= mem[mem_ra];
		end
	end

	always_comb begin
		state_d = state_q;
		cmd_d = cmd_q;
		key_d = key_q;
		val_d = val_q;
		dist_d = dist_q;
		ind_d = ind_q;
		occ_d = occ_q;
		emit_d = emit_q;
		res_d = res_q;
		out_d = out_q;
		out_valid_d = out_valid_q && rsp_stall;
		mem_we = 1'b0;
		mem_wa = ind_q[IDX_W-1:0];
		mem_wd = '0;
		rd_en = 1'b0;
		mem_ra = ind_q[IDX_W-1:0];
		case (state_q)
			FSM_IDLE: begin
				if (req_valid) begin
					cmd_d = req.command;
					key_d = req.key_in;
					val_d = req.data_in;
					dist_d = '0;
					if (req.command == CMD_CLEAR) begin
						ind_d = '0;
						emit_d = 1'b1;
						state_d = FSM_SWEEP;
					end else begin
						state_d = FSM_HASH;
					end
				end
			end
			FSM_HASH: begin
				ind_d = IND_W'(prod[TABLE_LOG-1:0]);
				state_d = FSM_READ;
			end
			FSM_READ: begin
				if (in_bound) begin
					rd_en = 1'b1;
					state_d = FSM_CHECK;
				end else begin
					res_d.entry_count = occ_q;
					res_d.value_out = val_q;
					if (is_insert) begin
						res_d.status = ST_DROPPED;
						res_d.dropped_key = key_q;
					end else begin
						res_d.status = ST_MISSING;
						res_d.dropped_key = '0;
					end
					state_d = FSM_DONE;
				end
			end
			FSM_CHECK: begin
				res_d.dropped_key = '0;
				ind_d = ind_q + IND_W'(1);
				dist_d = dist_q + DIST_W'(1);
				state_d = FSM_READ;
				if (is_insert) begin
					if (!rd_s1.full) begin
						mem_we = 1'b1;
						mem_wd = '{full: 1'b1, distance: dist_q, key: key_q, value: val_q};
						occ_d = occ_q + COUNT_W'(1);
						res_d = '{status: ST_NEW, value_out: '0, dropped_key: '0,
							entry_count: occ_q + COUNT_W'(1)};
						state_d = FSM_DONE;
					end else if (rd_s1.key == key_q) begin
						mem_we = 1'b1;
						mem_wd = '{full: 1'b1, distance: rd_s1.distance, key: rd_s1.key,
							value: val_q};
						res_d = '{status: ST_UPDATED, value_out: '0, dropped_key: '0,
							entry_count: occ_q};
						state_d = FSM_DONE;
					end else if (rd_s1.distance < dist_q) begin
						mem_we = 1'b1;
						mem_wd = '{full: 1'b1, distance: dist_q, key: key_q, value: val_q};
						key_d = rd_s1.key;
						val_d = rd_s1.value;
						dist_d = rd_s1.distance + DIST_W'(1);
					end
				end else begin
					if (!rd_s1.full || (rd_s1.distance < dist_q)) begin
						res_d = '{status: ST_MISSING, value_out: val_q, dropped_key: '0,
							entry_count: occ_q};
						state_d = FSM_DONE;
					end else if (rd_s1.key == key_q) begin
						res_d = '{status: ST_FOUND, value_out: rd_s1.value, dropped_key: '0,
							entry_count: occ_q};
						state_d = FSM_DONE;
					end
				end
			end
			FSM_SWEEP: begin
				mem_we = 1'b1;
				ind_d = ind_q + IND_W'(1);
				if (ind_q == IND_W'(CELL_COUNT - 1)) begin
					occ_d = '0;
					res_d = '{status: ST_CLEARED, value_out: '0, dropped_key: '0,
						entry_count: '0};
					state_d = emit_q ? FSM_DONE : FSM_IDLE;
				end
			end
			FSM_DONE: begin
				if (!out_valid_q || !rsp_stall) begin
					out_d = res_q;
					out_valid_d = 1'b1;
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_SWEEP;
			cmd_q <= CMD_CLEAR;
			dist_q <= '0;
			ind_q <= '0;
			occ_q <= '0;
			emit_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cmd_q <= cmd_d;
			dist_q <= dist_d;
			ind_q <= ind_d;
			occ_q <= occ_d;
			emit_q <= emit_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
		val_q <= val_d;
		res_q <= res_d;
		out_q <= out_d;
	end

	`RH_ASSERT_NOW(a_occ_range, clk, arst_n, 1'b1, occ_q <= COUNT_W'(CELL_COUNT))
	`RH_ASSERT_NOW(a_check_index, clk, arst_n, state_q == FSM_CHECK, ind_q < IND_W'(CELL_COUNT))
	`RH_ASSERT_NOW(a_insert_dist, clk, arst_n, state_q == FSM_CHECK && is_insert, dist_q < DIST_W'(TABLE_LOG))
	`RH_ASSERT_NEXT(a_done_loads, clk, arst_n, state_q == FSM_DONE && !out_valid_q, out_valid_q && state_q == FSM_IDLE)
endmodule

### verif/tb.sv
// Testbench for the Robin Hood hash table: random insert/lookup/spare/clear items checked against a local table model.
module tb;
	import rhht_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LOG = 10;
	localparam int SIZE = 1 << LOG;
	localparam int CELLS = SIZE + LOG + 1;
	localparam int IDLE_LIMIT = 20000;

	class hash_scoreboard;
		logic [31:0] keys [CELLS];
		logic [31:0] vals [CELLS];
		int unsigned distance [CELLS];
		bit used [CELLS];
		int unsigned fill;
		rsp_item_t expected_q [$];
		int errors;

		function void empty_table();
			foreach (used[i]) begin
				used[i] = 0;
				distance[i] = 0;
			end
			fill = 0;
		endfunction

		function int unsigned home_of(logic [31:0] k);
			logic [31:0] x;
			x = (k >> HASH_SHIFT) ^ k;
			x = x * HASH_MULT;
			return x & (SIZE - 1);
		endfunction

		function void note_request(req_item_t r);
			rsp_item_t o;
			logic [31:0] k, v, tk, tv;
			int unsigned ind, d, td;
			k = r.key_in;
			v = r.data_in;
			ind = home_of(k);
			o = '0;
			if (r.command == CMD_CLEAR) begin
				empty_table();
				o.status = ST_CLEARED;
			end else if (r.command == CMD_INSERT) begin
				o.status = ST_DROPPED;
				for (d = 0; d < LOG && ind < CELLS; d++, ind++) begin
					if (!used[ind]) begin
						used[ind] = 1;
						distance[ind] = d;
						keys[ind] = k;
						vals[ind] = v;
						fill++;
						o.status = ST_NEW;
						break;
					end else if (keys[ind] == k) begin
						vals[ind] = v;
						o.status = ST_UPDATED;
						break;
					end else if (distance[ind] < d) begin
						tk = keys[ind];
						tv = vals[ind];
						td = distance[ind];
						keys[ind] = k;
						vals[ind] = v;
						distance[ind] = d;
						k = tk;
						v = tv;
						d = td;
					end
				end
				if (o.status == ST_DROPPED) begin
					o.value_out = v;
					o.dropped_key = k;
				end
			end else begin
				o.status = ST_MISSING;
				o.value_out = v;
				for (d = 0; d <= LOG && ind < CELLS; d++, ind++) begin
					if (!used[ind] || distance[ind] < d)
						break;
					if (keys[ind] == k) begin
						o.value_out = vals[ind];
						o.status = ST_FOUND;
						break;
					end
				end
			end
			o.entry_count = fill[COUNT_W-1:0];
			expected_q.push_back(o);
		endfunction

		function void check_result(rsp_item_t got);
			rsp_item_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", got);
				return;
			end
			e = expected_q.pop_front();
			if (got !== e) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp st=%0d val=%h dk=%h cnt=%0d got st=%0d val=%h dk=%h cnt=%0d",
						e.status, e.value_out, e.dropped_key, e.entry_count,
						got.status, got.value_out, got.dropped_key, got.entry_count);
			end
		endfunction
	endclass

	logic clk, arst_n, req_valid, req_stall, rsp_valid, rsp_stall;
	req_item_t req;
	rsp_item_t rsp;
	hash_scoreboard sb;
	int idle_cycles;
	bit hold_rsp;
	logic [31:0] key_pool [64];

	robin_hood_hash_table_top #(.TABLE_LOG(LOG)) DUT (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			sb.note_request(req);
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(rsp);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver stall pattern with periods of no stall
	initial begin
		int mode;
		rsp_stall = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(5, 60)) begin
				@(posedge clk);
				if (hold_rsp)
					rsp_stall <= 1;
				else if (mode == 0)
					rsp_stall <= 0;
				else
					rsp_stall <= ($urandom_range(0, 3) < mode);
			end
		end
	end

	task automatic send(input logic [1:0] c, input logic [31:0] k, input logic [31:0] v);
		req_valid <= 1;
		req <= '{command: c, key_in: k, data_in: v};
		do @(posedge clk); while (req_stall);
	endtask

	task automatic gap();
		req_valid <= 0;
		repeat ($urandom_range(1, 8)) @(posedge clk);
	endtask

	task automatic drain();
		req_valid <= 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic random_item();
		logic [31:0] k;
		int sel;
		sel = $urandom_range(0, 99);
		k = (sel < 70) ? key_pool[$urandom_range(0, 63)] : $urandom;
		if (sel < 45)
			send(CMD_INSERT, k, $urandom);
		else if (sel < 97)
			send($urandom_range(0, 1) ? CMD_LOOKUP : CMD_SPARE, k, $urandom);
		else
			send(CMD_CLEAR, $urandom, $urandom);
	endtask

	initial begin
		sb = new();
		sb.empty_table();
		arst_n = 0;
		req_valid = 0;
		req = '0;
		hold_rsp = 0;
		idle_cycles = 0;
		foreach (key_pool[i])
			key_pool[i] = (i < 32) ? i * 32'h10001 : $urandom;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, every command, update, unused command, overflow
		send(CMD_LOOKUP, 32'h0, 32'hFFFFFFFF);
		send(CMD_INSERT, 32'h0, 32'h0);
		send(CMD_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send(CMD_INSERT, 32'h0, 32'hA5A5A5A5);
		send(CMD_LOOKUP, 32'h0, 32'h1);
		send(CMD_SPARE, 32'hFFFFFFFF, 32'h0);
		send(CMD_LOOKUP, 32'h12345678, 32'hDEADBEEF);
		// same-home keys: keys below 2^16 whose low ten bits are zero share one home cell
		for (int i = 0; i < 12; i++)
			send(CMD_INSERT, {i[21:0], 10'd0}, 32'hC0DE0000 + i);
		send(CMD_LOOKUP, {22'd11, 10'd0}, 32'h0);
		send(CMD_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send(CMD_LOOKUP, 32'h0, 32'h5);
		drain();

		// long receiver hold while the sender keeps offering
		fork
			begin
				hold_rsp = 1;
				repeat (300) @(posedge clk);
				hold_rsp = 0;
			end
			for (int i = 0; i < 20; i++)
				random_item();
		join
		drain();

		for (int i = 0; i < 1130; i++) begin
			random_item();
			if ($urandom_range(0, 9) == 0)
				gap();
			if (i == 600)
				drain();
		end
		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
